// ----- rtl/timestamp_ordered_request_queue_top_assert.svh -----
`ifndef TIMESTAMP_ORDERED_REQUEST_QUEUE_TOP_ASSERT_SVH
`define TIMESTAMP_ORDERED_REQUEST_QUEUE_TOP_ASSERT_SVH

// Same-cycle check: when ante holds, cons must hold.
`define TORQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: when ante holds, cons must hold in the next cycle.
`define TORQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/torq_pkg.sv -----
package torq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TIME_W        = 15;
    localparam int ID_W          = 4;
    localparam int KEY_W         = TIME_W + ID_W;
    localparam int OP_W          = 2;
    localparam int ST_W          = 2;
    localparam int OCC_W_DEFAULT = $clog2(DEPTH_DEFAULT + 1);

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_POP   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CMP,
        S_POP_RD,
        S_POP_LD,
        S_RESP
    } fsm_t;

endpackage

// ----- rtl/torq_req_if.sv -----
interface torq_req_if;
    logic                          valid;
    logic                          ready;
    logic [torq_pkg::OP_W-1:0]     operation;
    logic [torq_pkg::TIME_W-1:0]   entry_time;
    logic [torq_pkg::ID_W-1:0]     entry_id;

    modport source (output valid, operation, entry_time, entry_id, input ready);
    modport sink   (input valid, operation, entry_time, entry_id, output ready);
endinterface

// ----- rtl/torq_rsp_if.sv -----
interface torq_rsp_if #(
    parameter int OCC_W = torq_pkg::OCC_W_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic [torq_pkg::ST_W-1:0]     status;
    logic                          is_empty;
    logic [torq_pkg::TIME_W-1:0]   head_time;
    logic [torq_pkg::ID_W-1:0]     head_id;
    logic [OCC_W-1:0]              occupancy;

    modport source (output valid, status, is_empty, head_time, head_id, occupancy,
                    input ready);
    modport sink   (input valid, status, is_empty, head_time, head_id, occupancy,
                    output ready);
endinterface

// ----- rtl/torq_ram.sv -----
module torq_ram #(
    parameter int DEPTH = torq_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = torq_pkg::KEY_W
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/timestamp_ordered_request_queue_top.sv -----
// Channel  Dir  Fields
// req      in   operation, entry_time, entry_id
// rsp      out  status, is_empty, head_time, head_id, occupancy
//
// Query and rejected requests go from idle straight to the response state.
// Pop passes through POP_RD and POP_LD: one memory read fetches the new head.
// Push scans down from the tail: each stored entry whose key is not below the
// new key is read and written one slot up through the RAM's read and write
// ports, then the new entry is written into the freed slot.
// Reset clears count, ring base and control; RAM contents need no clearing.
// A stalled response holds the output register; the next request is taken
// once the previous one is handed to that register.
`include "timestamp_ordered_request_queue_top_assert.svh"

module timestamp_ordered_request_queue_top #(
    parameter int DEPTH = torq_pkg::DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    torq_req_if.sink          req,
    torq_rsp_if.source        rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int KW = torq_pkg::KEY_W;
    localparam int IW = torq_pkg::ID_W;

    torq_pkg::fsm_t state_reg, state_next;

    logic [CW-1:0]             count_reg, count_next;
    logic [AW-1:0]             base_reg, base_next;
    logic [CW-1:0]             j_reg, j_next;
    logic [KW-1:0]             key_reg, key_next;
    logic [KW-1:0]             head_reg, head_next;
    logic [torq_pkg::ST_W-1:0] status_reg, status_next;

    logic                      rsp_valid_reg, rsp_valid_next;
    logic [torq_pkg::ST_W-1:0] rsp_status_reg, rsp_status_next;
    logic                      rsp_empty_reg, rsp_empty_next;
    logic [KW-1:0]             rsp_head_reg, rsp_head_next;
    logic [CW-1:0]             rsp_occ_reg, rsp_occ_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [KW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [KW-1:0] rd_data;

    logic          accept;
    logic          rsp_free;
    logic [CW-1:0] j_m1;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] ofs);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(ofs);
        if (s >= SW'(DEPTH))
        begin
            s = s - SW'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    torq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (KW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req.ready = (state_reg == torq_pkg::S_IDLE);
    assign accept    = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign j_m1      = j_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            torq_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.operation == torq_pkg::OP_PUSH)
                    begin
                        state_next = (count_reg == CW'(DEPTH)) ? torq_pkg::S_RESP
                                                               : torq_pkg::S_SCAN;
                    end
                    else if (req.operation == torq_pkg::OP_POP)
                    begin
                        state_next = (count_reg == '0) ? torq_pkg::S_RESP
                                                       : torq_pkg::S_POP_RD;
                    end
                    else
                    begin
                        state_next = torq_pkg::S_RESP;
                    end
                end
            end
            torq_pkg::S_SCAN:
            begin
                state_next = (j_reg == '0) ? torq_pkg::S_RESP : torq_pkg::S_CMP;
            end
            torq_pkg::S_CMP:
            begin
                state_next = (rd_data < key_reg) ? torq_pkg::S_RESP : torq_pkg::S_SCAN;
            end
            torq_pkg::S_POP_RD:
            begin
                state_next = torq_pkg::S_POP_LD;
            end
            torq_pkg::S_POP_LD:
            begin
                state_next = torq_pkg::S_RESP;
            end
            torq_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = torq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = torq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next      = count_reg;
        base_next       = base_reg;
        j_next          = j_reg;
        key_next        = key_reg;
        head_next       = head_reg;
        status_next     = status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_empty_next  = rsp_empty_reg;
        rsp_head_next   = rsp_head_reg;
        rsp_occ_next    = rsp_occ_reg;
        wr_en           = 1'b0;
        wr_addr         = phys(base_reg, j_reg);
        wr_data         = key_reg;
        rd_addr         = phys(base_reg, j_m1);
        case (state_reg)
            torq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    key_next    = {req.entry_time, req.entry_id};
                    j_next      = count_reg;
                    status_next = torq_pkg::ST_OK;
                    if (req.operation == torq_pkg::OP_PUSH)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = torq_pkg::ST_FULL;
                        end
                    end
                    else if (req.operation == torq_pkg::OP_POP)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = torq_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            base_next  = phys(base_reg, CW'(1));
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
            end
            torq_pkg::S_SCAN:
            begin
                if (j_reg == '0)
                begin
                    wr_en      = 1'b1;
                    head_next  = key_reg;
                    count_next = count_reg + 1'b1;
                end
            end
            torq_pkg::S_CMP:
            begin
                wr_en = 1'b1;
                if (rd_data < key_reg)
                begin
                    count_next = count_reg + 1'b1;
                end
                else
                begin
                    wr_data = rd_data;
                    j_next  = j_m1;
                end
            end
            torq_pkg::S_POP_RD:
            begin
                rd_addr = base_reg;
            end
            torq_pkg::S_POP_LD:
            begin
                head_next = rd_data;
            end
            torq_pkg::S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = status_reg;
                    rsp_empty_next  = (count_reg == '0);
                    rsp_head_next   = (count_reg == '0) ? '0 : head_reg;
                    rsp_occ_next    = count_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= torq_pkg::S_IDLE;
            count_reg     <= '0;
            base_reg      <= '0;
            j_reg         <= '0;
            status_reg    <= torq_pkg::ST_OK;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            j_reg         <= j_next;
            status_reg    <= status_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        head_reg       <= head_next;
        rsp_status_reg <= rsp_status_next;
        rsp_empty_reg  <= rsp_empty_next;
        rsp_head_reg   <= rsp_head_next;
        rsp_occ_reg    <= rsp_occ_next;
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = rsp_status_reg;
    assign rsp.is_empty  = rsp_empty_reg;
    assign rsp.head_time = rsp_head_reg[KW-1:IW];
    assign rsp.head_id   = rsp_head_reg[IW-1:0];
    assign rsp.occupancy = rsp_occ_reg;

    `TORQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CW'(DEPTH),
        "entry count exceeds depth")
    `TORQ_ASSERT_NOW(a_write_in_scan, clk, rst_n, wr_en,
        (state_reg == torq_pkg::S_SCAN) || (state_reg == torq_pkg::S_CMP),
        "RAM write outside insertion scan")
    `TORQ_ASSERT_NEXT(a_pop_count, clk, rst_n,
        accept && (req.operation == torq_pkg::OP_POP) && (count_reg != '0),
        count_reg == $past(count_reg) - 1'b1, "pop did not retire one entry")
    `TORQ_ASSERT_NEXT(a_full_drop, clk, rst_n,
        accept && (req.operation == torq_pkg::OP_PUSH) && (count_reg == CW'(DEPTH)),
        (status_reg == torq_pkg::ST_FULL) && (state_reg == torq_pkg::S_RESP),
        "push into full queue not dropped")

endmodule

// ----- bench/tb_timestamp_ordered_request_queue_top.sv -----
`timescale 1ns / 1ps

typedef struct packed {
    logic [torq_pkg::ST_W-1:0]          status;
    logic                               is_empty;
    logic [torq_pkg::TIME_W-1:0]        head_time;
    logic [torq_pkg::ID_W-1:0]          head_id;
    logic [torq_pkg::OCC_W_DEFAULT-1:0] occupancy;
} queue_view_t;

class request_queue_tracker;
    localparam int QUEUE_DEPTH = torq_pkg::DEPTH_DEFAULT;
    localparam int OCC_W       = torq_pkg::OCC_W_DEFAULT;

    logic [torq_pkg::KEY_W-1:0] sorted_keys[$];
    queue_view_t                pending_views[$];
    int                         mismatches;
    int                         pushes;
    int                         pops;
    int                         queries;
    int                         full_drops;
    int                         empty_pops;
    int                         peak_occupancy;

    function new();
        mismatches     = 0;
        pushes         = 0;
        pops           = 0;
        queries        = 0;
        full_drops     = 0;
        empty_pops     = 0;
        peak_occupancy = 0;
    endfunction

    function int pending_count();
        return pending_views.size();
    endfunction

    function void note_request(logic [torq_pkg::OP_W-1:0] operation,
                               logic [torq_pkg::TIME_W-1:0] entry_time,
                               logic [torq_pkg::ID_W-1:0] entry_id);
        logic [torq_pkg::KEY_W-1:0] key;
        logic [torq_pkg::KEY_W-1:0] head;
        int                         pos;
        queue_view_t                view;
        key         = {entry_time, entry_id};
        view.status = torq_pkg::ST_OK;
        if (operation == torq_pkg::OP_PUSH)
        begin
            pushes++;
            if (sorted_keys.size() >= QUEUE_DEPTH)
            begin
                view.status = torq_pkg::ST_FULL;
                full_drops++;
            end
            else
            begin
                pos = 0;
                while (pos < sorted_keys.size() && sorted_keys[pos] < key)
                    pos++;
                sorted_keys.insert(pos, key);
            end
        end
        else if (operation == torq_pkg::OP_POP)
        begin
            pops++;
            if (sorted_keys.size() == 0)
            begin
                view.status = torq_pkg::ST_EMPTY;
                empty_pops++;
            end
            else
            begin
                void'(sorted_keys.pop_front());
            end
        end
        else
        begin
            queries++;
        end
        head           = (sorted_keys.size() != 0) ? sorted_keys[0] : '0;
        view.is_empty  = (sorted_keys.size() == 0);
        view.head_time = head[torq_pkg::KEY_W-1:torq_pkg::ID_W];
        view.head_id   = head[torq_pkg::ID_W-1:0];
        view.occupancy = OCC_W'(sorted_keys.size());
        if (sorted_keys.size() > peak_occupancy)
            peak_occupancy = sorted_keys.size();
        pending_views.push_back(view);
    endfunction

    function void compare_field(string field, int expected, int actual);
        if (expected != actual)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected, actual);
            mismatches++;
        end
    endfunction

    function void check_response(queue_view_t actual);
        queue_view_t expected;
        if (pending_views.size() == 0)
        begin
            $display("%0t: response with no request outstanding, expected none, actual %p",
                     $time, actual);
            mismatches++;
            return;
        end
        expected = pending_views.pop_front();
        compare_field("status", expected.status, actual.status);
        compare_field("is_empty", expected.is_empty, actual.is_empty);
        compare_field("head_time", expected.head_time, actual.head_time);
        compare_field("head_id", expected.head_id, actual.head_id);
        compare_field("occupancy", expected.occupancy, actual.occupancy);
    endfunction
endclass

module tb_timestamp_ordered_request_queue_top;

    localparam int                        TW            = torq_pkg::TIME_W;
    localparam int                        IW            = torq_pkg::ID_W;
    localparam logic [torq_pkg::OP_W-1:0] OP_SPARE      = 2'd3;
    localparam int                        RANDOM_COUNT  = 1910;
    localparam int                        STALL_LIMIT   = 2000;
    localparam int                        SETTLE_CYCLES = 50;

    logic clk;
    logic rst_n;
    bit   send_idle_on;
    bit   recv_idle_on;
    int   idle_cycles;
    int   responses_seen;

    request_queue_tracker tracker;

    torq_req_if req_ch();
    torq_rsp_if rsp_ch();

    timestamp_ordered_request_queue_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    task automatic send_request(logic [torq_pkg::OP_W-1:0] operation,
                                logic [TW-1:0] entry_time, logic [IW-1:0] entry_id);
        int gap;
        gap = send_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.operation  <= operation;
        req_ch.entry_time <= entry_time;
        req_ch.entry_id   <= entry_id;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        tracker.note_request(operation, entry_time, entry_id);
    endtask

    // hold off new requests until every response is back
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending_count() != 0)
            @(posedge clk);
    endtask

    function automatic logic [TW-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return TW'($urandom_range(0, 7));
            5:       return TW'($urandom_range(16380, 16390));
            default: return TW'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic [IW-1:0] pick_id();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return IW'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [torq_pkg::OP_W-1:0] pick_operation(int mode);
        int roll;
        roll = $urandom_range(0, 99);
        case (mode)
            0:       return (roll < 85) ? torq_pkg::OP_PUSH : (roll < 95) ? torq_pkg::OP_POP :
                            (roll < 98) ? torq_pkg::OP_QUERY : OP_SPARE;
            1:       return (roll < 15) ? torq_pkg::OP_PUSH : (roll < 95) ? torq_pkg::OP_POP :
                            (roll < 98) ? torq_pkg::OP_QUERY : OP_SPARE;
            default: return (roll < 45) ? torq_pkg::OP_PUSH : (roll < 85) ? torq_pkg::OP_POP :
                            (roll < 95) ? torq_pkg::OP_QUERY : OP_SPARE;
        endcase
    endfunction

    initial
    begin
        int sent;
        int burst_len;
        int mode;
        bit paused;
        tracker           = new();
        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.operation  = torq_pkg::OP_QUERY;
        req_ch.entry_time = '0;
        req_ch.entry_id   = '0;
        rsp_ch.ready      = 1'b0;
        send_idle_on      = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(torq_pkg::OP_QUERY, '1, '1);
        send_request(torq_pkg::OP_POP, 15'd12345, 4'd9);
        send_request(OP_SPARE, '1, '1);
        send_request(torq_pkg::OP_PUSH, '1, '1);
        send_request(torq_pkg::OP_PUSH, '0, '0);
        send_request(torq_pkg::OP_PUSH, '0, '0);
        send_request(torq_pkg::OP_PUSH, '1, '0);
        send_request(torq_pkg::OP_PUSH, 15'd16384, 4'd8);
        send_request(torq_pkg::OP_PUSH, 15'd16384, 4'd7);
        send_request(torq_pkg::OP_PUSH, '0, '1);
        send_request(torq_pkg::OP_QUERY, 15'h5555, 4'hA);
        send_request(OP_SPARE, 15'h2AAA, 4'h5);
        repeat (8)
            send_request(torq_pkg::OP_POP, TW'($urandom_range(0, 32767)),
                         IW'($urandom_range(0, 15)));
        send_request(torq_pkg::OP_PUSH, 15'h5555, 4'hA);
        send_request(torq_pkg::OP_PUSH, 15'h2AAA, 4'h5);
        drain_responses();

        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_COUNT)
        begin
            mode         = $urandom_range(0, 2);
            burst_len    = $urandom_range(8, 40);
            send_idle_on = ($urandom_range(0, 3) != 0);
            repeat (burst_len)
            begin
                send_request(pick_operation(mode), pick_time(), pick_id());
                sent++;
            end
            if (!paused && sent >= RANDOM_COUNT / 2)
            begin
                drain_responses();
                paused = 1'b1;
            end
        end
        req_ch.valid <= 1'b0;

        @(posedge clk);
        while (tracker.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d pushes, %0d pops and %0d queries; peak occupancy %0d.",
                 tracker.pushes, tracker.pops, tracker.queries, tracker.peak_occupancy);
        $display("Saw %0d pushes dropped on a full queue and %0d pops on an empty queue.",
                 tracker.full_drops, tracker.empty_pops);
        if (tracker.mismatches == 0 && tracker.pending_count() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int stall;
        queue_view_t actual;
        recv_idle_on   = 1'b1;
        responses_seen = 0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = recv_idle_on ? $urandom_range(0, 8) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            actual.status    = rsp_ch.status;
            actual.is_empty  = rsp_ch.is_empty;
            actual.head_time = rsp_ch.head_time;
            actual.head_id   = rsp_ch.head_id;
            actual.occupancy = rsp_ch.occupancy;
            tracker.check_response(actual);
            responses_seen++;
            if (responses_seen % 37 == 0)
                recv_idle_on = ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
        else
        begin
            idle_cycles <= 0;
        end
    end

endmodule
